@@ sv/hrhp_pkg.sv @@
package hrhp_pkg;

    // command codes carried with each input item
    typedef enum logic [1:0] {
        CMD_NAME  = 2'd0,
        CMD_VALUE = 2'd1,
        CMD_END   = 2'd2,
        CMD_RESET = 2'd3
    } cmd_t;

    // header kinds reported at end of line
    typedef enum logic [2:0] {
        KIND_OTHER         = 3'd0,
        KIND_CONNECTION    = 3'd1,
        KIND_LENGTH        = 3'd2,
        KIND_RANGE         = 3'd3,
        KIND_EXPIRES       = 3'd4,
        KIND_LAST_MODIFIED = 3'd5
    } kind_t;

    typedef struct packed {
        cmd_t        command;
        logic [7:0]  data_byte;
        logic        alive_default;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        kind_t       header_kind;
        logic        persistent;
        logic        length_valid;
        logic [63:0] body_length;
        logic        range_valid;
        logic [63:0] range_start;
        logic [63:0] range_end;
        logic [63:0] range_size;
    } out_item_t;

    localparam int NUM_NAMES = 5;

    // text constants, left aligned and padded with spaces to 16 characters
    localparam logic [127:0] NAME_TEXT [NUM_NAMES] = '{
        "connection:     ",
        "content-length: ",
        "content-range:  ",
        "expires:        ",
        "last-modified:  "
    };
    localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{4'd11, 4'd15, 4'd14, 4'd8, 4'd14};

    localparam logic [127:0] CLOSE_TEXT = "close           ";
    localparam logic [127:0] ALIVE_TEXT = "keep-alive      ";
    localparam logic [127:0] BYTES_TEXT = "bytes           ";
    localparam logic [3:0]   CLOSE_LEN  = 4'd5;
    localparam logic [3:0]   ALIVE_LEN  = 4'd10;
    localparam logic [3:0]   BYTES_LEN  = 4'd5;

    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // character k of a padded text constant
    function automatic logic [7:0] text_char(input logic [127:0] s, input logic [3:0] k);
        logic [3:0] r;
        r = 4'd15 - k;
        return s[{r, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

@@ sv/http_response_header_parser.sv @@
// HTTP response header parser. Each input item carries one command: a header
// name byte, a value byte, end of header line, or reset of the response state.
// Name bytes are matched case-insensitively against Connection, Content-Length,
// Content-Range, Expires and Last-Modified; value bytes are checked and decimal
// numbers accumulated (saturating at 2^64-1). Only the end-of-line command
// gives a result item: the line's outcome and kind together with the stored
// keep-alive flag, content length and content range. An item that is taken
// sits in the input register and is worked off from there, and the result of
// an end-of-line item is written to the output register; an item can be
// taken every cycle, the only stall being an end-of-line item whose result
// finds the output register still occupied.
module http_response_header_parser #(
    parameter int MAX_NAME_LEN = 15
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  hrhp_pkg::in_item_t    s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output hrhp_pkg::out_item_t   m_item
);

    localparam int NAME_POS_W = $clog2(MAX_NAME_LEN + 1);
    localparam logic [NAME_POS_W-1:0] NAME_POS_MAX = NAME_POS_W'(MAX_NAME_LEN);

    // value parser phases for Content-Length
    localparam logic [3:0] LP_WS     = 4'd1;
    // value parser phases for Content-Range
    localparam logic [3:0] RP_TOKEN     = 4'd0;
    localparam logic [3:0] RP_START_WS  = 4'd1;
    localparam logic [3:0] RP_START     = 4'd2;
    localparam logic [3:0] RP_END_NONE  = 4'd3;
    localparam logic [3:0] RP_END_WS    = 4'd4;
    localparam logic [3:0] RP_END       = 4'd5;
    localparam logic [3:0] RP_SIZE_NONE = 4'd6;
    localparam logic [3:0] RP_SIZE_WS   = 4'd7;
    localparam logic [3:0] RP_SIZE      = 4'd8;
    localparam logic [3:0] LP_DIGITS    = RP_START;
    // Connection value mismatch flags held in the phase register
    localparam int CONN_NOT_CLOSE = 0;
    localparam int CONN_NOT_ALIVE = 1;

    // input register
    logic                 in_valid_reg;
    hrhp_pkg::in_item_t   in_item_reg;

    // line and response state
    logic [NAME_POS_W-1:0]          name_pos_reg, name_pos_next;
    logic [hrhp_pkg::NUM_NAMES-1:0] name_match_reg, name_match_next;
    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  value_pos_reg, value_pos_next;
    logic        value_err_reg, value_err_next;
    logic [63:0] acc_reg, acc_next;
    logic        alive_reg, alive_next;
    logic        length_ok_reg, length_ok_next;
    logic [63:0] length_reg, length_next;
    logic        range_ok_reg, range_ok_next;
    logic [63:0] start_reg, start_next;
    logic [63:0] end_reg, end_next;
    logic [63:0] size_reg, size_next;

    // result register
    logic                 m_valid_reg;
    hrhp_pkg::out_item_t  m_item_reg, m_item_next;

    logic            proc_fire;
    logic [7:0]      c;
    logic [7:0]      lc;
    logic            c_digit;
    logic            c_space;
    hrhp_pkg::kind_t kind;
    logic [67:0]     acc_wide;
    logic [63:0]     acc_digit;
    logic            ok;
    logic            range_done;
    logic [63:0]     size_cand;

    // the item in the input register moves on unless its result has no room
    assign proc_fire = in_valid_reg &&
                       (in_item_reg.command != hrhp_pkg::CMD_END || !m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    assign c       = in_item_reg.data_byte;
    assign lc      = hrhp_pkg::to_lower(c);
    assign c_digit = hrhp_pkg::is_digit(c);
    assign c_space = hrhp_pkg::is_space(c);

    // decimal accumulate with saturation
    assign acc_wide  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {64'b0, c[3:0]};
    assign acc_digit = (|acc_wide[67:64]) ? {64{1'b1}} : acc_wide[63:0];

    // kind of the current line, first matching name wins
    always_comb begin
        kind = hrhp_pkg::KIND_OTHER;
        for (int i = hrhp_pkg::NUM_NAMES - 1; i >= 0; i--) begin
            if (name_match_reg[i] &&
                name_pos_reg == NAME_POS_W'(hrhp_pkg::NAME_LEN[i])) begin
                kind = hrhp_pkg::kind_t'(3'(i + 1));
            end
        end
    end

    // state update for one item
    always_comb begin
        name_pos_next   = name_pos_reg;
        name_match_next = name_match_reg;
        phase_next      = phase_reg;
        value_pos_next  = value_pos_reg;
        value_err_next  = value_err_reg;
        acc_next        = acc_reg;
        alive_next      = alive_reg;
        length_ok_next  = length_ok_reg;
        length_next     = length_reg;
        range_ok_next   = range_ok_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        size_next       = size_reg;
        ok              = 1'b1;
        range_done      = 1'b0;
        size_cand       = 64'd0;

        case (in_item_reg.command)
            hrhp_pkg::CMD_NAME: begin
                if (value_pos_reg == 4'd0) begin
                    for (int i = 0; i < hrhp_pkg::NUM_NAMES; i++) begin
                        if (name_pos_reg >= NAME_POS_W'(hrhp_pkg::NAME_LEN[i]) ||
                            lc != hrhp_pkg::text_char(hrhp_pkg::NAME_TEXT[i],
                                                      name_pos_reg[3:0])) begin
                            name_match_next[i] = 1'b0;
                        end
                    end
                    if (name_pos_reg < NAME_POS_MAX) begin
                        name_pos_next = name_pos_reg + 1'b1;
                    end
                end
            end

            hrhp_pkg::CMD_VALUE: begin
                if (kind == hrhp_pkg::KIND_CONNECTION) begin
                    if (value_pos_reg >= hrhp_pkg::CLOSE_LEN ||
                        lc != hrhp_pkg::text_char(hrhp_pkg::CLOSE_TEXT, value_pos_reg)) begin
                        phase_next[CONN_NOT_CLOSE] = 1'b1;
                    end
                    if (value_pos_reg >= hrhp_pkg::ALIVE_LEN ||
                        lc != hrhp_pkg::text_char(hrhp_pkg::ALIVE_TEXT, value_pos_reg)) begin
                        phase_next[CONN_NOT_ALIVE] = 1'b1;
                    end
                end else if (!value_err_reg && kind == hrhp_pkg::KIND_LENGTH) begin
                    if (c_digit) begin
                        acc_next   = acc_digit;
                        phase_next = LP_DIGITS;
                    end else if (c_space && phase_reg < LP_DIGITS) begin
                        phase_next = LP_WS;
                    end else begin
                        value_err_next = 1'b1;
                    end
                end else if (!value_err_reg && kind == hrhp_pkg::KIND_RANGE) begin
                    case (phase_reg)
                        RP_TOKEN: begin
                            if (c_space) begin
                                if (value_pos_reg == hrhp_pkg::BYTES_LEN) begin
                                    phase_next = RP_START_WS;
                                end else begin
                                    value_err_next = 1'b1;
                                end
                            end else if (value_pos_reg >= hrhp_pkg::BYTES_LEN ||
                                         lc != hrhp_pkg::text_char(hrhp_pkg::BYTES_TEXT,
                                                                   value_pos_reg)) begin
                                value_err_next = 1'b1;
                            end
                        end
                        RP_START_WS: begin
                            if (c_digit) begin
                                acc_next   = acc_digit;
                                phase_next = RP_START;
                            end else if (c == hrhp_pkg::CHAR_DASH) begin
                                start_next = 64'd0;
                                phase_next = RP_END_NONE;
                            end else if (!c_space) begin
                                value_err_next = 1'b1;
                            end
                        end
                        RP_START: begin
                            if (c_digit) begin
                                acc_next = acc_digit;
                            end else if (c == hrhp_pkg::CHAR_DASH) begin
                                start_next = acc_reg;
                                acc_next   = 64'd0;
                                phase_next = RP_END_NONE;
                            end else begin
                                value_err_next = 1'b1;
                            end
                        end
                        RP_END_NONE: begin
                            if (c_digit) begin
                                acc_next   = acc_digit;
                                phase_next = RP_END;
                            end else if (c_space) begin
                                phase_next = RP_END_WS;
                            end else if (c == hrhp_pkg::CHAR_SLASH) begin
                                end_next   = 64'd0;
                                phase_next = RP_SIZE_NONE;
                            end else begin
                                value_err_next = 1'b1;
                            end
                        end
                        RP_END_WS: begin
                            if (c_digit) begin
                                acc_next   = acc_digit;
                                phase_next = RP_END;
                            end else if (!c_space) begin
                                value_err_next = 1'b1;
                            end
                        end
                        RP_END: begin
                            if (c_digit) begin
                                acc_next = acc_digit;
                            end else if (c == hrhp_pkg::CHAR_SLASH) begin
                                end_next   = acc_reg;
                                acc_next   = 64'd0;
                                phase_next = RP_SIZE_NONE;
                            end else begin
                                value_err_next = 1'b1;
                            end
                        end
                        RP_SIZE_NONE, RP_SIZE_WS: begin
                            if (c_digit) begin
                                acc_next   = acc_digit;
                                phase_next = RP_SIZE;
                            end else if (c_space) begin
                                phase_next = RP_SIZE_WS;
                            end else begin
                                value_err_next = 1'b1;
                            end
                        end
                        RP_SIZE: begin
                            if (c_digit) begin
                                acc_next = acc_digit;
                            end else begin
                                value_err_next = 1'b1;
                            end
                        end
                        default: begin
                            value_err_next = 1'b1;
                        end
                    endcase
                end
                if (value_pos_reg != 4'd15) begin
                    value_pos_next = value_pos_reg + 4'd1;
                end
            end

            hrhp_pkg::CMD_END: begin
                if (kind == hrhp_pkg::KIND_CONNECTION) begin
                    if (!phase_reg[CONN_NOT_CLOSE] && value_pos_reg == hrhp_pkg::CLOSE_LEN) begin
                        alive_next = 1'b0;
                    end else if (!phase_reg[CONN_NOT_ALIVE] &&
                                 value_pos_reg == hrhp_pkg::ALIVE_LEN) begin
                        alive_next = 1'b1;
                    end else begin
                        ok = 1'b0;
                    end
                end else if (kind == hrhp_pkg::KIND_LENGTH) begin
                    ok             = !value_err_reg && phase_reg != LP_WS;
                    length_next    = ok ? acc_reg : 64'd0;
                    length_ok_next = ok;
                end else if (kind == hrhp_pkg::KIND_RANGE) begin
                    // close the range: end and size come from the last phase
                    if (!value_err_reg) begin
                        range_done = 1'b1;
                        case (phase_reg)
                            RP_END_NONE:  end_next  = 64'd0;
                            RP_END:       end_next  = acc_reg;
                            RP_SIZE_NONE: size_cand = 64'd0;
                            RP_SIZE:      size_cand = acc_reg;
                            default:      range_done = 1'b0;
                        endcase
                    end
                    ok = range_done && (start_reg <= end_next);
                    if (ok) begin
                        size_next = size_cand;
                    end
                    range_ok_next = ok;
                end
                name_pos_next   = '0;
                name_match_next = '1;
                phase_next      = 4'd0;
                value_pos_next  = 4'd0;
                value_err_next  = 1'b0;
                acc_next        = 64'd0;
            end

            hrhp_pkg::CMD_RESET: begin
                name_pos_next   = '0;
                name_match_next = '1;
                phase_next      = 4'd0;
                value_pos_next  = 4'd0;
                value_err_next  = 1'b0;
                acc_next        = 64'd0;
                alive_next      = in_item_reg.alive_default;
                length_ok_next  = 1'b0;
                length_next     = 64'd0;
                range_ok_next   = 1'b0;
                start_next      = 64'd0;
                end_next        = 64'd0;
                size_next       = 64'd0;
            end

            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // result item for an end of line
    always_comb begin
        m_item_next.accepted     = ok;
        m_item_next.header_kind  = kind;
        m_item_next.persistent   = alive_next;
        m_item_next.length_valid = length_ok_next;
        m_item_next.body_length  = length_ok_next ? length_next : 64'd0;
        m_item_next.range_valid  = range_ok_next;
        m_item_next.range_start  = range_ok_next ? start_next : 64'd0;
        m_item_next.range_end    = range_ok_next ? end_next : 64'd0;
        m_item_next.range_size   = range_ok_next ? size_next : 64'd0;
    end

    // input register, state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            name_pos_reg   <= '0;
            name_match_reg <= '1;
            phase_reg      <= 4'd0;
            value_pos_reg  <= 4'd0;
            value_err_reg  <= 1'b0;
            acc_reg        <= 64'd0;
            alive_reg      <= 1'b0;
            length_ok_reg  <= 1'b0;
            length_reg     <= 64'd0;
            range_ok_reg   <= 1'b0;
            start_reg      <= 64'd0;
            end_reg        <= 64'd0;
            size_reg       <= 64'd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proc_fire) begin
                name_pos_reg   <= name_pos_next;
                name_match_reg <= name_match_next;
                phase_reg      <= phase_next;
                value_pos_reg  <= value_pos_next;
                value_err_reg  <= value_err_next;
                acc_reg        <= acc_next;
                alive_reg      <= alive_next;
                length_ok_reg  <= length_ok_next;
                length_reg     <= length_next;
                range_ok_reg   <= range_ok_next;
                start_reg      <= start_next;
                end_reg        <= end_next;
                size_reg       <= size_next;
            end
            if (proc_fire && in_item_reg.command == hrhp_pkg::CMD_END) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (proc_fire && in_item_reg.command == hrhp_pkg::CMD_END) begin
            m_item_reg <= m_item_next;
        end
    end

    // an end of line that is worked off always leaves a result behind
    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_item_reg.command == hrhp_pkg::CMD_END |=> m_valid_reg)
        else $error("end of line item produced no result");

    // input side only stalls while an item is held
    a_stall_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled without a blocked result");

    // a range line reports its own outcome as the range valid flag
    a_range_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.header_kind == hrhp_pkg::KIND_RANGE |->
            m_item_reg.range_valid == m_item_reg.accepted)
        else $error("range valid flag disagrees with line outcome");

    // a length line reports its own outcome as the length valid flag
    a_length_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_item_reg.header_kind == hrhp_pkg::KIND_LENGTH |->
            m_item_reg.length_valid == m_item_reg.accepted)
        else $error("length valid flag disagrees with line outcome");

    // name bytes after value bytes within a line leave the name matcher unchanged
    a_name_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_item_reg.command == hrhp_pkg::CMD_NAME && value_pos_reg != 4'd0 |=>
            $stable(name_pos_reg) && $stable(name_match_reg))
        else $error("name state changed after value bytes");

endmodule
